@@ hw/rtl/rcs_lex_pkg.sv @@
// ----------------------------------------------------------------------------
// rcs_lex_pkg
// shared types and constants for the rcs token lexer
// ----------------------------------------------------------------------------
package rcs_lex_pkg;

    typedef enum logic [1:0] {
        MODE_IDLE   = 2'd0,
        MODE_WORD   = 2'd1,
        MODE_STR    = 2'd2,
        MODE_STR_AT = 2'd3
    } lex_mode_t;

    typedef enum logic [2:0] {
        TT_STRING = 3'd0,
        TT_SYMBOL = 3'd1,
        TT_NUMBER = 3'd2,
        TT_SEMI   = 3'd3,
        TT_COLON  = 3'd4,
        TT_EOI    = 3'd5
    } tok_class_t;

    localparam logic OP_DATA = 1'b0;
    localparam logic OP_EOI  = 1'b1;

    localparam logic KIND_BYTE = 1'b0;
    localparam logic KIND_END  = 1'b1;

    localparam logic [7:0] CH_AT    = 8'h40;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;

    // result queue depth, must hold two words beyond what is in flight
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);

    typedef struct packed {
        logic        kind;
        tok_class_t  tok_class;
        logic [7:0]  data;
        logic        last;
    } lex_result_t;

endpackage

@@ hw/rtl/rcs_token_lexer.sv @@
// ----------------------------------------------------------------------------
// rcs_token_lexer
// streaming tokenizer for rcs-format byte streams
// ----------------------------------------------------------------------------
// One word enters per cycle: a data byte (s_tuser low) or an end-of-input
// marker (s_tuser high). Each input word yields zero, one or two result
// words: content bytes of a token (m_tuser low) and token-end markers
// (m_tuser high) carrying the token type in m_tdata[2:0]. Strings are
// @-quoted with @@ standing for one @; words are symbols unless made only of
// digits and dots, then numbers; ';' and ':' are tokens of their own and
// also end a word. The input word is held in a register, then the lexer
// state update and result generation run in one combinational pass and the
// results land in a four-entry result queue. Sustained rate is one input
// word per cycle while the results keep up; a second result (closing quote,
// word ended by ';' or ':', end of input inside a token) is absorbed by the
// queue. m_tlast marks the final result of an input.
// ----------------------------------------------------------------------------
module rcs_token_lexer
    import rcs_lex_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] byte_in
    input  logic        s_tuser,   // [0] op

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [2:0] tok_class, [10:3] data_out, [15:11] zero
    output logic        m_tuser,   // [0] kind
    output logic        m_tlast    // last result of this input word
);

    // input register
    logic       in_valid_reg;
    logic       in_op_reg;
    logic [7:0] in_byte_reg;

    // lexer state
    lex_mode_t  mode_reg, mode_next;
    logic       saw_letter_reg, saw_letter_next;

    // result queue
    lex_result_t               q_mem_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]       q_wr_ptr_reg;
    logic [QUEUE_AW-1:0]       q_rd_ptr_reg;
    logic [QUEUE_AW:0]         q_count_reg;
    logic [QUEUE_AW:0]         q_count_next;

    logic       q_room;
    logic       fire;
    logic       pop;

    // byte classes
    logic b_space, b_num, b_at, b_semi, b_colon;

    // results of this pass
    lex_result_t res0, res1;
    logic [1:0]  res_n;

    // idle handling of the current byte
    logic        idle_emit;
    lex_result_t idle_res;
    lex_mode_t   idle_mode;
    logic        idle_saw;

    // queue can take two more words without counting a pop
    assign q_room   = (q_count_reg <= (QUEUE_AW+1)'(QUEUE_DEPTH - 2));
    assign fire     = in_valid_reg && q_room;
    assign s_tready = !in_valid_reg || q_room;
    assign pop      = m_tvalid && m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
        if (s_tready && s_tvalid) begin
            in_op_reg   <= s_tuser;
            in_byte_reg <= s_tdata;
        end
    end

    // byte classification
    always_comb begin
        b_space = (in_byte_reg == CH_SPACE)
               || (in_byte_reg >= CH_TAB && in_byte_reg <= CH_CR);
        b_num   = (in_byte_reg >= CH_ZERO && in_byte_reg <= CH_NINE)
               || (in_byte_reg == CH_DOT);
        b_at    = (in_byte_reg == CH_AT);
        b_semi  = (in_byte_reg == CH_SEMI);
        b_colon = (in_byte_reg == CH_COLON);
    end

    // what a byte does between tokens
    always_comb begin
        idle_emit = 1'b0;
        idle_res  = '{kind: KIND_BYTE, tok_class: TT_STRING, data: 8'd0, last: 1'b0};
        idle_mode = MODE_IDLE;
        idle_saw  = 1'b0;
        priority if (b_space) begin
            idle_emit = 1'b0;
        end else if (b_semi) begin
            idle_emit          = 1'b1;
            idle_res.kind      = KIND_END;
            idle_res.tok_class = TT_SEMI;
        end else if (b_colon) begin
            idle_emit          = 1'b1;
            idle_res.kind      = KIND_END;
            idle_res.tok_class = TT_COLON;
        end else if (b_at) begin
            idle_mode = MODE_STR;
        end else begin
            idle_emit     = 1'b1;
            idle_res.data = in_byte_reg;
            idle_mode     = MODE_WORD;
            idle_saw      = !b_num;
        end
    end

    // next state
    always_comb begin
        mode_next       = mode_reg;
        saw_letter_next = saw_letter_reg;
        if (fire) begin
            if (in_op_reg == OP_EOI) begin
                mode_next       = MODE_IDLE;
                saw_letter_next = 1'b0;
            end else begin
                unique case (mode_reg)
                    MODE_IDLE: begin
                        mode_next       = idle_mode;
                        saw_letter_next = idle_saw;
                    end
                    MODE_WORD: begin
                        if (b_space || b_semi || b_colon) begin
                            mode_next       = MODE_IDLE;
                            saw_letter_next = 1'b0;
                        end else begin
                            saw_letter_next = saw_letter_reg || !b_num;
                        end
                    end
                    MODE_STR: begin
                        if (b_at) begin
                            mode_next = MODE_STR_AT;
                        end
                    end
                    MODE_STR_AT: begin
                        if (b_at) begin
                            mode_next = MODE_STR;
                        end else begin
                            mode_next       = idle_mode;
                            saw_letter_next = idle_saw;
                        end
                    end
                    default: begin
                        mode_next = MODE_IDLE;
                    end
                endcase
            end
        end
    end

    // results
    always_comb begin
        lex_result_t word_end;
        lex_result_t str_end;
        lex_result_t eoi_end;
        lex_result_t content;

        word_end = '{kind: KIND_END, tok_class: saw_letter_reg ? TT_SYMBOL : TT_NUMBER,
                     data: 8'd0, last: 1'b0};
        str_end  = '{kind: KIND_END, tok_class: TT_STRING, data: 8'd0, last: 1'b0};
        eoi_end  = '{kind: KIND_END, tok_class: TT_EOI, data: 8'd0, last: 1'b0};
        content  = '{kind: KIND_BYTE, tok_class: TT_STRING, data: in_byte_reg, last: 1'b0};

        res0  = content;
        res1  = content;
        res_n = 2'd0;

        if (in_op_reg == OP_EOI) begin
            unique case (mode_reg)
                MODE_IDLE: begin
                    res0  = eoi_end;
                    res_n = 2'd1;
                end
                MODE_WORD: begin
                    res0  = word_end;
                    res1  = eoi_end;
                    res_n = 2'd2;
                end
                default: begin
                    res0  = str_end;
                    res1  = eoi_end;
                    res_n = 2'd2;
                end
            endcase
        end else begin
            unique case (mode_reg)
                MODE_IDLE: begin
                    res0  = idle_res;
                    res_n = idle_emit ? 2'd1 : 2'd0;
                end
                MODE_WORD: begin
                    if (b_space) begin
                        res0  = word_end;
                        res_n = 2'd1;
                    end else if (b_semi || b_colon) begin
                        res0  = word_end;
                        res1  = idle_res;
                        res_n = 2'd2;
                    end else begin
                        res_n = 2'd1;
                    end
                end
                MODE_STR: begin
                    res_n = b_at ? 2'd0 : 2'd1;
                end
                default: begin
                    // just after an '@' inside a string
                    if (b_at) begin
                        res_n = 2'd1;
                    end else begin
                        res0  = str_end;
                        res1  = idle_res;
                        res_n = idle_emit ? 2'd2 : 2'd1;
                    end
                end
            endcase
        end

        if (res_n == 2'd1) begin
            res0.last = 1'b1;
        end
        if (res_n == 2'd2) begin
            res1.last = 1'b1;
        end
    end

    // queue count
    always_comb begin
        q_count_next = q_count_reg;
        if (fire) begin
            q_count_next = q_count_next + (QUEUE_AW+1)'(res_n);
        end
        if (pop) begin
            q_count_next = q_count_next - (QUEUE_AW+1)'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg       <= MODE_IDLE;
            saw_letter_reg <= 1'b0;
            q_wr_ptr_reg   <= '0;
            q_rd_ptr_reg   <= '0;
            q_count_reg    <= '0;
        end else begin
            mode_reg       <= mode_next;
            saw_letter_reg <= saw_letter_next;
            q_count_reg    <= q_count_next;
            if (fire) begin
                q_wr_ptr_reg <= q_wr_ptr_reg + QUEUE_AW'(res_n);
            end
            if (pop) begin
                q_rd_ptr_reg <= q_rd_ptr_reg + QUEUE_AW'(1);
            end
        end
    end

    // queue storage, payload only
    always_ff @(posedge aclk) begin
        if (fire && res_n != 2'd0) begin
            q_mem_reg[q_wr_ptr_reg] <= res0;
        end
        if (fire && res_n == 2'd2) begin
            q_mem_reg[q_wr_ptr_reg + QUEUE_AW'(1)] <= res1;
        end
    end

    // output side
    lex_result_t head;
    assign head     = q_mem_reg[q_rd_ptr_reg];
    assign m_tvalid = (q_count_reg != '0);
    assign m_tdata  = {5'd0, head.data, head.tok_class};
    assign m_tuser  = head.kind;
    assign m_tlast  = head.last;

endmodule
